FILE: src/tcpq_pkg.sv
// Package with payload types, codes and constants of the three-class priority queue.
`timescale 1ns / 1ps

package tcpq_pkg;

    // Field widths.
    localparam int HANDLE_W   = 32;
    localparam int PRIO_W     = 8;
    localparam int REQ_W      = 2;
    localparam int CLASS_W    = 2;
    localparam int CAP_W      = 11;
    localparam int NUM_CLASSES = 3;

    // Default store depth per class and reset value of the capacity register.
    localparam int DEFAULT_DEPTH = 1024;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Class codes, also used as the index of the per-class state.
    localparam logic [CLASS_W-1:0] CLASS_LOW    = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_NORMAL = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_HIGH   = 2'd2;

    // Priority thresholds of the high and normal classes.
    localparam logic [PRIO_W-1:0] PRIO_HIGH_MIN   = 8'd3;
    localparam logic [PRIO_W-1:0] PRIO_NORMAL_MIN = 8'd1;

    // Request payload.
    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [HANDLE_W-1:0] message_handle;
        logic [PRIO_W-1:0]   priority_level;
    } req_t;

    // Result payload.
    typedef struct packed {
        logic                ok;
        logic [HANDLE_W-1:0] popped_handle;
        logic [CLASS_W-1:0]  popped_class;
        logic [CAP_W-1:0]    occupancy;
    } rsp_t;

endpackage

FILE: src/tcpq_store.sv
// Handle store of one class: a synchronous memory with one write and one registered read port.
`timescale 1ns / 1ps

module tcpq_store import tcpq_pkg::*; #(
    parameter int DEPTH = DEFAULT_DEPTH,
    parameter int PTR_W = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [PTR_W-1:0]    wr_addr,
    input  logic [HANDLE_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [PTR_W-1:0]    rd_addr,
    output logic [HANDLE_W-1:0] rd_data
);

    logic [HANDLE_W-1:0] mem [DEPTH];
    logic [HANDLE_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/three_class_priority_queue.sv
// Top level of the three-class strict-priority queue: pointer control and result pipeline.
`timescale 1ns / 1ps
//
// Requests arrive on the s_ channel (valid/ready, payload s_req): push, pop or clear.
// Each request produces exactly one result on the m_ channel (payload m_rsp), in order.
// A push files its handle into the high (priority 3 and up), normal (1, 2) or low (0)
// class unless the total occupancy has reached min(capacity, QUEUE_DEPTH). A pop
// returns the oldest handle of the highest non-empty class, or ok 0 when empty.
// The capacity register is written through cfg_wr_en / cfg_wr_data; the user must do
// so only while idle, as the block itself does not enforce it.
// A request's result is held in the read stage and then loaded into the output
// register. Throughput: one request per cycle while s_ready is high. Pointers and
// counts update in the transfer cycle; the pop data comes from the registered read
// port of the class memory, read with the transfer, so the next request sees the
// updated pointers at once.
//
// Reset clears all pointers and counts and sets the capacity to 1024; the handle
// memories are not cleared, and no entry is read before it is written.
// When the receiver stalls, the output register holds the result, one more result
// waits in the read stage, and then s_ready drops until the output drains.
//
module three_class_priority_queue import tcpq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  req_t             s_req,
    output logic             m_valid,
    input  logic             m_ready,
    output rsp_t             m_rsp,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CIDX_W = $clog2(NUM_CLASSES);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(QUEUE_DEPTH);

    // Per-class pointers and counts, total count and capacity.
    logic [PTR_W-1:0] head_reg [NUM_CLASSES];
    logic [PTR_W-1:0] tail_reg [NUM_CLASSES];
    logic [CNT_W-1:0] cnt_reg  [NUM_CLASSES];
    logic [PTR_W-1:0] head_next [NUM_CLASSES];
    logic [PTR_W-1:0] tail_next [NUM_CLASSES];
    logic [CNT_W-1:0] cnt_next  [NUM_CLASSES];
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CAP_W-1:0] cap_reg;

    // Read stage and output register.
    logic                p1_valid_reg;
    logic                p1_ok_reg;
    logic                p1_pop_reg;
    logic [CLASS_W-1:0]  p1_class_reg;
    logic [CAP_W-1:0]    p1_occ_reg;
    logic                m_valid_reg;
    rsp_t                m_rsp_reg;

    logic                s_xfer;
    logic                out_load;
    logic                is_push, is_pop, is_clear;
    logic                push_ok, pop_ok;
    logic [CLASS_W-1:0]  push_cls, pop_cls;
    logic [CMP_W-1:0]    total_cmp, cap_cmp;
    logic [PTR_W-1:0]    push_addr, pop_addr;
    logic [HANDLE_W-1:0] rd_data [NUM_CLASSES];
    logic [HANDLE_W-1:0] pop_data;

    assign out_load = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !p1_valid_reg || out_load;
    assign s_xfer   = s_valid && s_ready;

    // Decode the request.
    assign is_push  = (s_req.req_type == REQ_PUSH);
    assign is_pop   = (s_req.req_type == REQ_POP);
    assign is_clear = (s_req.req_type == REQ_CLEAR);

    // Class of a push from its priority.
    always_comb begin
        priority if (s_req.priority_level >= PRIO_HIGH_MIN) begin
            push_cls = CLASS_HIGH;
        end else if (s_req.priority_level >= PRIO_NORMAL_MIN) begin
            push_cls = CLASS_NORMAL;
        end else begin
            push_cls = CLASS_LOW;
        end
    end

    // Class served by a pop: highest non-empty class.
    always_comb begin
        priority if (cnt_reg[CLASS_HIGH] != '0) begin
            pop_cls = CLASS_HIGH;
        end else if (cnt_reg[CLASS_NORMAL] != '0) begin
            pop_cls = CLASS_NORMAL;
        end else begin
            pop_cls = CLASS_LOW;
        end
    end

    // Admission: the effective capacity is the smaller of the register and the depth.
    assign total_cmp = CMP_W'(total_reg);
    assign cap_cmp   = CMP_W'(cap_reg);
    assign push_ok   = is_push && (total_cmp < cap_cmp) && (total_cmp < DEPTH_CMP);
    assign pop_ok    = is_pop && (total_reg != '0);

    assign push_addr = tail_reg[push_cls[CIDX_W-1:0]];
    assign pop_addr  = head_reg[pop_cls[CIDX_W-1:0]];

    // Next pointer and count values.
    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            head_next[c] = head_reg[c];
            tail_next[c] = tail_reg[c];
            cnt_next[c]  = cnt_reg[c];
            if (is_clear) begin
                head_next[c] = '0;
                tail_next[c] = '0;
                cnt_next[c]  = '0;
            end else if (push_ok && (push_cls == CLASS_W'(c))) begin
                tail_next[c] = (tail_reg[c] == PTR_LAST) ? '0 : tail_reg[c] + 1'b1;
                cnt_next[c]  = cnt_reg[c] + 1'b1;
            end else if (pop_ok && (pop_cls == CLASS_W'(c))) begin
                head_next[c] = (head_reg[c] == PTR_LAST) ? '0 : head_reg[c] + 1'b1;
                cnt_next[c]  = cnt_reg[c] - 1'b1;
            end
        end
        priority if (is_clear) begin
            total_next = '0;
        end else if (push_ok) begin
            total_next = total_reg + 1'b1;
        end else if (pop_ok) begin
            total_next = total_reg - 1'b1;
        end else begin
            total_next = total_reg;
        end
    end

    // Pointer, count and capacity registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                cnt_reg[c]  <= '0;
            end
            total_reg <= '0;
            cap_reg   <= CAP_RESET;
        end else begin
            if (s_xfer) begin
                for (int c = 0; c < NUM_CLASSES; c++) begin
                    head_reg[c] <= head_next[c];
                    tail_reg[c] <= tail_next[c];
                    cnt_reg[c]  <= cnt_next[c];
                end
                total_reg <= total_next;
            end
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // One memory per class.
    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_store
        tcpq_store #(
            .DEPTH (QUEUE_DEPTH),
            .PTR_W (PTR_W)
        ) u_store (
            .aclk    (aclk),
            .wr_en   (s_xfer && push_ok && (push_cls == CLASS_W'(g))),
            .wr_addr (push_addr),
            .wr_data (s_req.message_handle),
            .rd_en   (s_xfer && pop_ok && (pop_cls == CLASS_W'(g))),
            .rd_addr (pop_addr),
            .rd_data (rd_data[g])
        );
    end

    // Read stage: control of the request whose memory read is under way.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p1_valid_reg <= s_xfer;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            p1_ok_reg    <= push_ok || pop_ok || is_clear;
            p1_pop_reg   <= pop_ok;
            p1_class_reg <= pop_cls;
            p1_occ_reg   <= CAP_W'(CMP_W'(total_next));
        end
    end

    assign pop_data = rd_data[p1_class_reg[CIDX_W-1:0]];

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_rsp_reg.ok            <= p1_ok_reg;
            m_rsp_reg.popped_handle <= p1_pop_reg ? pop_data : '0;
            m_rsp_reg.popped_class  <= p1_pop_reg ? p1_class_reg : CLASS_LOW;
            m_rsp_reg.occupancy     <= p1_occ_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    // The total always equals the sum of the class counts.
    a_total_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(total_reg) == CMP_W'(cnt_reg[0]) + CMP_W'(cnt_reg[1]) + CMP_W'(cnt_reg[2]))
        else $error("total count differs from the sum of class counts");

    // The total never exceeds the depth of a store.
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(total_reg) <= DEPTH_CMP)
        else $error("total count above queue depth");

    // A clear empties the queue.
    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && is_clear |=> total_reg == '0)
        else $error("queue not empty after clear");

    // A refused push leaves the occupancy unchanged.
    a_refused_push: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && is_push && !push_ok |=> $stable(total_reg))
        else $error("refused push changed the occupancy");

    // The read stage never overruns a stalled output.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && m_valid_reg && !m_ready |-> !s_ready)
        else $error("request taken while the result pipeline is full");

endmodule
